### rtl/core/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// shared constants, command and result codes, and the slot entry type of the
// multi-slot timer table
// ----------------------------------------------------------------------------
package tmt_pkg;

  localparam int SLOTS       = 16;
  localparam int PRIO_LEVELS = 4;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_RECONF = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;
  localparam logic [2:0] CMD_DELETE = 3'd5;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_FIRED   = 2'd2;
  localparam logic [1:0] KIND_IDLE    = 2'd3;

  typedef struct packed {
    logic        in_use;
    logic        paused;
    logic        micros;
    logic [2:0]  urg;
    logic [31:0] period;
    logic [31:0] due;
  } slot_entry_t;

endpackage

### rtl/core/tmt_cell.sv
// ----------------------------------------------------------------------------
// tmt_cell
// one timer slot of the rotating ring; holds the entry, passes it on when the
// ring steps and flags when the slot is running and due
// ----------------------------------------------------------------------------
module tmt_cell import tmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  slot_entry_t d,
  input  logic [31:0] time_millis,
  input  logic [31:0] time_micros,
  output slot_entry_t q,
  output logic        expired
);

  logic [31:0] now;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

  assign now     = q.micros ? time_micros : time_millis;
  assign expired = q.in_use && !q.paused && (now >= q.due);

endmodule

### rtl/core/tmt_rem.sv
// ----------------------------------------------------------------------------
// tmt_rem
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmt_rem import tmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      dvd <= {dvd[30:0], 1'b0};
    end
  end

endmodule

### rtl/core/multi_slot_timer_table.sv
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// table of timer slots with create, reconfigure, pause, resume, delete, tick
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that steps one slot per cycle, unless held,
// past a single update point, so every command takes one full turn of the ring.
// Resume of a paused periodic slot that has fallen behind holds the ring while
// the bit-serial remainder unit runs. A tick gives one beat per fired slot in
// slot order, the last one marked, or a single nothing-due beat; a stall on the
// result side holds the ring. No new command is taken until the current one
// has handed its final beat to the output register.
module multi_slot_timer_table import tmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  slot,
  input  logic [31:0] period,
  input  logic [31:0] start_offset,
  input  logic        use_micros,
  input  logic [2:0]  urgency,
  input  logic [31:0] time_millis,
  input  logic [31:0] time_micros,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [3:0]  slot_out,
  output logic [2:0]  fire_urgency,
  output logic        last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0]       state;
  logic [IDX_W-1:0] cnt;
  logic [2:0]       cmd_r;
  logic [7:0]       slot_r;
  logic [31:0]      per_r;
  logic [31:0]      off_r;
  logic             mic_r;
  logic [2:0]       urg_r;
  logic [31:0]      ms_r;
  logic [31:0]      us_r;
  logic             found;
  logic [IDX_W-1:0] res_slot;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_slot;
  logic [2:0]       pend_urg;

  slot_entry_t cell_q [SLOTS];
  slot_entry_t cell_d [SLOTS];
  logic        cell_exp [SLOTS];

  slot_entry_t head;
  slot_entry_t head_new;
  slot_entry_t load_entry;
  logic [31:0] now_head;
  logic [31:0] now_load;
  logic        slot_hit;
  logic        slot_ok;
  logic        urg_ok;
  logic        fire;
  logic        load_hit;
  logic        start_div;
  logic        emit_need;
  logic        out_free;
  logic        shift;
  logic        div_done;
  logic [31:0] div_rem;
  logic [1:0]  fin_kind;
  logic [IDX_W-1:0] fin_slot;
  logic [2:0]  fin_urg;

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_cell
      if (k == SLOTS - 1) begin : g_tail
        assign cell_d[k] = head_new;
      end else begin : g_link
        assign cell_d[k] = cell_q[k+1];
      end
      tmt_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .shift       (shift),
        .d           (cell_d[k]),
        .time_millis (ms_r),
        .time_micros (us_r),
        .q           (cell_q[k]),
        .expired     (cell_exp[k])
      );
    end
  endgenerate

  assign head       = cell_q[0];
  assign now_head   = head.micros ? us_r : ms_r;
  assign now_load   = mic_r ? us_r : ms_r;
  assign load_entry = '{in_use: 1'b1, paused: 1'b0, micros: mic_r, urg: urg_r,
                        period: per_r, due: now_load + off_r};
  assign slot_hit   = ({{(9-IDX_W){1'b0}}, cnt} == {1'b0, slot_r});
  assign slot_ok    = ({1'b0, slot_r} < 9'(SLOTS));
  assign urg_ok     = ({1'b0, urg_r} < 4'(PRIO_LEVELS));

  always_comb begin
    head_new  = head;
    fire      = 1'b0;
    load_hit  = 1'b0;
    start_div = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        if (cell_exp[0]) begin
          fire = 1'b1;
          if (head.period == '0) begin
            head_new = '0;
          end else begin
            head_new.due = head.due + head.period;
          end
        end
      end
      CMD_CREATE: begin
        if (!found && urg_ok && !head.in_use) begin
          head_new = load_entry;
          load_hit = 1'b1;
        end
      end
      CMD_RECONF: begin
        if (slot_hit && urg_ok && head.in_use) begin
          head_new = load_entry;
          load_hit = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (slot_hit) begin
          head_new.paused = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (slot_hit && head.paused && head.period != '0) begin
          if (now_head >= head.due) begin
            start_div = 1'b1;
          end else begin
            head_new.paused = 1'b0;
          end
        end
      end
      CMD_DELETE: begin
        if (slot_hit) begin
          head_new = '0;
        end
      end
      default: ;
    endcase
    if (state == S_DIV) begin
      head_new.paused = 1'b0;
      head_new.due    = now_head - div_rem + head.period;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign emit_need = (state == S_SCAN) && fire && pend_valid;
  assign shift     = ((state == S_SCAN) && !start_div && !(emit_need && !out_free)) ||
                     ((state == S_DIV) && div_done);
  assign in_stall  = (state != S_IDLE);

  tmt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_SCAN) && start_div),
    .dividend (now_head - head.due),
    .divisor  (head.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    fin_kind = KIND_REFUSED;
    fin_slot = '0;
    fin_urg  = '0;
    case (cmd_r)
      CMD_TICK: begin
        if (pend_valid) begin
          fin_kind = KIND_FIRED;
          fin_slot = pend_slot;
          fin_urg  = pend_urg;
        end else begin
          fin_kind = KIND_IDLE;
        end
      end
      CMD_CREATE: begin
        if (found) begin
          fin_kind = KIND_DONE;
          fin_slot = res_slot;
        end
      end
      CMD_RECONF: begin
        if (found) begin
          fin_kind = KIND_DONE;
        end
      end
      CMD_PAUSE, CMD_RESUME, CMD_DELETE: begin
        if (slot_ok) begin
          fin_kind = KIND_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((emit_need && shift) || ((state == S_END) && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state      <= S_SCAN;
            cnt        <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
          end
        end
        S_SCAN, S_DIV: begin
          if ((state == S_SCAN) && start_div) begin
            state <= S_DIV;
          end else if (shift) begin
            if (load_hit) begin
              found <= 1'b1;
            end
            if (fire) begin
              pend_valid <= 1'b1;
            end
            if (cnt == IDX_W'(SLOTS - 1)) begin
              cnt   <= '0;
              state <= S_END;
            end else begin
              cnt <= cnt + 1'b1;
              if (state == S_DIV) begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_END: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      cmd_r  <= command;
      slot_r <= slot;
      per_r  <= period;
      off_r  <= start_offset;
      mic_r  <= use_micros;
      urg_r  <= urgency;
      ms_r   <= time_millis;
      us_r   <= time_micros;
    end
    if (((state == S_SCAN) || (state == S_DIV)) && shift && !((state == S_SCAN) && start_div))
    begin
      if (load_hit) begin
        res_slot <= cnt;
      end
      if (fire) begin
        pend_slot <= cnt;
        pend_urg  <= head.urg;
      end
    end
    if (emit_need && shift) begin
      kind         <= KIND_FIRED;
      slot_out     <= 4'(pend_slot);
      fire_urgency <= pend_urg;
      last         <= 1'b0;
    end else if ((state == S_END) && out_free) begin
      kind         <= fin_kind;
      slot_out     <= 4'(fin_slot);
      fire_urgency <= fin_urg;
      last         <= 1'b1;
    end
  end

endmodule

### rtl/core/tmt_checker.sv
// ----------------------------------------------------------------------------
// tmt_checker
// port-level checks on the result channel of the timer table
// ----------------------------------------------------------------------------
module tmt_checker import tmt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [3:0] slot_out,
  input logic [2:0] fire_urgency,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot_out) && $stable(last))
    else $error("result beat changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_FIRED |-> last)
    else $error("non-fire result beat without last");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_IDLE || kind == KIND_REFUSED) |-> slot_out == '0 && fire_urgency == '0)
    else $error("refused or idle beat carries slot data");

  a_done_urg: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> fire_urgency == '0)
    else $error("done beat carries a priority");

endmodule

bind multi_slot_timer_table tmt_checker u_tmt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .slot_out     (slot_out),
  .fire_urgency (fire_urgency),
  .last         (last)
);
